// ----- hdl/spc_pkg.sv -----
package spc_pkg;

  localparam int unsigned PulseW = 16;
  localparam int unsigned AngleW = 8;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned ProdW  = PulseW + AngleW;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [PulseW-1:0] pulse_t;
  typedef logic [AngleW-1:0] angle_t;
  typedef logic [ProdW-1:0]  prod_t;

  typedef enum logic [FuncW-1:0] {
    FN_TICK      = 3'd0,
    FN_INIT      = 3'd1,
    FN_SET_ANGLE = 3'd2,
    FN_SET_PULSE = 3'd3,
    FN_START     = 3'd4,
    FN_STOP      = 3'd5,
    FN_GET_ANGLE = 3'd6,
    FN_DEINIT    = 3'd7
  } func_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_PULSE = 3'd0,
    CFG_MAX_PULSE = 3'd1,
    CFG_MAX_ANGLE = 3'd2,
    CFG_FRAME_TOP = 3'd3
  } cfg_idx_t;

  localparam pulse_t MinPulseRst = 16'd1000;
  localparam pulse_t MaxPulseRst = 16'd2000;
  localparam angle_t MaxAngleRst = 8'd180;
  localparam pulse_t FrameTopRst = 16'd19999;

endpackage

// ----- hdl/spc_mul.sv -----
module spc_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  spc_pkg::pulse_t       mcand,
  input  spc_pkg::angle_t       mplier,
  output logic                  done,
  output spc_pkg::prod_t        product
);

  localparam int unsigned AW = spc_pkg::AngleW;
  localparam int unsigned PW = spc_pkg::PulseW;
  localparam int unsigned CW = $clog2(AW);

  logic                 busy_r;
  logic                 done_r;
  logic [CW-1:0]        cnt_r;
  spc_pkg::pulse_t      mcand_r;
  spc_pkg::prod_t       prod_r;
  spc_pkg::prod_t       prod_nxt;
  logic [PW:0]          sum;

  // shift-add, one multiplier bit per cycle
  always_comb begin
    sum      = {1'b0, prod_r[spc_pkg::ProdW-1:AW]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
    prod_nxt = {sum, prod_r[AW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        prod_r  <= {{PW{1'b0}}, mplier};
        mcand_r <= mcand;
        cnt_r   <= '0;
        busy_r  <= 1'b1;
      end else if (busy_r) begin
        prod_r <= prod_nxt;
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CW'(AW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign product = prod_r;

endmodule

// ----- hdl/spc_div.sv -----
module spc_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  spc_pkg::prod_t   dividend,
  input  spc_pkg::pulse_t  divisor,
  output logic             done,
  output spc_pkg::prod_t   quotient
);

  localparam int unsigned QW = spc_pkg::ProdW;
  localparam int unsigned DW = spc_pkg::PulseW;
  localparam int unsigned CW = $clog2(QW);

  logic                  busy_r;
  logic                  done_r;
  logic [CW-1:0]         cnt_r;
  spc_pkg::pulse_t       dsr_r;
  spc_pkg::pulse_t       rem_r;
  spc_pkg::pulse_t       rem_nxt;
  spc_pkg::prod_t        quo_r;
  spc_pkg::prod_t        quo_nxt;
  logic [DW:0]           shifted;
  logic [DW:0]           diff;
  logic                  ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem_r, quo_r[QW-1]};
    diff    = shifted - {1'b0, dsr_r};
    ge      = shifted >= {1'b0, dsr_r};
    rem_nxt = ge ? diff[DW-1:0] : shifted[DW-1:0];
    quo_nxt = {quo_r[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- hdl/servo_pulse_channel_core.sv -----
// One RC servo channel driven by a command stream, one result transaction per
// command. Tick, start, stop, get angle, deinit and every rejected command go
// from ST_IDLE to ST_DONE, which loads the result into the output register
// once that register is empty or not stalled. Init, set angle and set pulse
// run the angle/pulse mapping in ST_CALC through a bit-serial 8-step multiplier
// followed by a 24-step restoring divider, and then go on to ST_DONE alike.
// One command is in flight at a time; the next is accepted as soon as the
// previous result is loaded, even while that result is still stalled.
// Configuration writes are taken at any time and are expected only when idle.
module servo_pulse_channel_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [spc_pkg::FuncW-1:0]        in_func,
  input  logic [spc_pkg::AngleW-1:0]       in_angle,
  input  logic [spc_pkg::PulseW-1:0]       in_pulse_us,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_status,
  output logic                             out_pin_level,
  output logic [spc_pkg::AngleW-1:0]       out_angle_now,
  output logic [spc_pkg::PulseW-1:0]       out_pulse_now,
  input  logic                             cfg_we,
  input  logic [spc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [spc_pkg::PulseW-1:0]       cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_t;

  state_t          state_r;
  spc_pkg::pulse_t min_pulse_r;
  spc_pkg::pulse_t max_pulse_r;
  spc_pkg::angle_t max_angle_r;
  spc_pkg::pulse_t frame_top_r;

  spc_pkg::pulse_t frame_count_r;
  spc_pkg::pulse_t cur_pulse_r;
  spc_pkg::angle_t cur_angle_r;
  logic            running_r;
  logic            ready_r;

  logic            status_r;
  logic            mode_pulse_r;
  logic            init_r;
  spc_pkg::angle_t a_r;
  spc_pkg::pulse_t p_r;
  spc_pkg::pulse_t divisor_r;

  logic            out_valid_r;
  logic            out_status_r;
  logic            out_pin_r;
  spc_pkg::angle_t out_angle_r;
  spc_pkg::pulse_t out_pulse_r;

  spc_pkg::func_t  func;
  logic            accept;
  logic            out_load;
  logic            calib_ok;
  spc_pkg::pulse_t span;
  spc_pkg::pulse_t p_cl;
  logic            reject;
  logic            mul_start;
  spc_pkg::pulse_t mul_mcand;
  spc_pkg::angle_t mul_mplier;
  logic            mul_done;
  spc_pkg::prod_t  mul_product;
  logic            div_done;
  spc_pkg::prod_t  div_quo;

  assign func     = spc_pkg::func_t'(in_func);
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign calib_ok = (max_angle_r != '0) && (min_pulse_r < max_pulse_r);
  assign span     = max_pulse_r - min_pulse_r;

  always_comb begin
    if (in_pulse_us < min_pulse_r) begin
      p_cl = min_pulse_r;
    end else if (in_pulse_us > max_pulse_r) begin
      p_cl = max_pulse_r;
    end else begin
      p_cl = in_pulse_us;
    end
  end

  always_comb begin
    reject     = 1'b0;
    mul_start  = 1'b0;
    mul_mcand  = span;
    mul_mplier = in_angle;
    unique case (func)
      spc_pkg::FN_TICK: begin
        reject = 1'b0;
      end
      spc_pkg::FN_INIT: begin
        reject     = !calib_ok;
        mul_start  = accept && calib_ok;
        mul_mplier = max_angle_r >> 1;
      end
      spc_pkg::FN_SET_ANGLE: begin
        reject    = !ready_r || !calib_ok || (in_angle > max_angle_r);
        mul_start = accept && !reject;
      end
      spc_pkg::FN_SET_PULSE: begin
        reject     = !ready_r || !calib_ok;
        mul_start  = accept && !reject;
        mul_mcand  = p_cl - min_pulse_r;
        mul_mplier = max_angle_r;
      end
      spc_pkg::FN_START, spc_pkg::FN_STOP, spc_pkg::FN_GET_ANGLE,
      spc_pkg::FN_DEINIT: begin
        reject = !ready_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      min_pulse_r   <= spc_pkg::MinPulseRst;
      max_pulse_r   <= spc_pkg::MaxPulseRst;
      max_angle_r   <= spc_pkg::MaxAngleRst;
      frame_top_r   <= spc_pkg::FrameTopRst;
      frame_count_r <= '0;
      cur_pulse_r   <= '0;
      cur_angle_r   <= '0;
      running_r     <= 1'b0;
      ready_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          spc_pkg::CFG_MIN_PULSE: min_pulse_r <= cfg_wdata;
          spc_pkg::CFG_MAX_PULSE: max_pulse_r <= cfg_wdata;
          spc_pkg::CFG_MAX_ANGLE: max_angle_r <= cfg_wdata[spc_pkg::AngleW-1:0];
          spc_pkg::CFG_FRAME_TOP: frame_top_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            status_r <= reject;
            if (mul_start) begin
              mode_pulse_r <= (func == spc_pkg::FN_SET_PULSE);
              init_r       <= (func == spc_pkg::FN_INIT);
              a_r          <= mul_mplier;
              p_r          <= p_cl;
              divisor_r    <= (func == spc_pkg::FN_SET_PULSE) ? span :
                              {{(spc_pkg::PulseW-spc_pkg::AngleW){1'b0}}, max_angle_r};
              state_r      <= ST_CALC;
            end else begin
              state_r <= ST_DONE;
              if (!reject) begin
                unique case (func)
                  spc_pkg::FN_TICK: begin
                    frame_count_r <= (frame_count_r >= frame_top_r) ? '0 :
                                     frame_count_r + 1'b1;
                  end
                  spc_pkg::FN_START: running_r <= 1'b1;
                  spc_pkg::FN_STOP:  running_r <= 1'b0;
                  spc_pkg::FN_DEINIT: begin
                    running_r <= 1'b0;
                    ready_r   <= 1'b0;
                  end
                  default: ;
                endcase
              end
            end
          end
        end
        ST_CALC: begin
          if (div_done) begin
            if (mode_pulse_r) begin
              cur_pulse_r <= p_r;
              cur_angle_r <= div_quo[spc_pkg::AngleW-1:0];
            end else begin
              cur_angle_r <= a_r;
              cur_pulse_r <= min_pulse_r + div_quo[spc_pkg::PulseW-1:0];
            end
            if (init_r) begin
              ready_r   <= 1'b1;
              running_r <= 1'b1;
            end
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_status_r <= status_r;
            out_pin_r    <= running_r && (frame_count_r < cur_pulse_r);
            out_angle_r  <= cur_angle_r;
            out_pulse_r  <= cur_pulse_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  spc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .done    (mul_done),
    .product (mul_product)
  );

  spc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_done),
    .dividend (mul_product),
    .divisor  (divisor_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_pin_level = out_pin_r;
  assign out_angle_now = out_angle_r;
  assign out_pulse_now = out_pulse_r;

endmodule

// ----- hdl/spc_checker.sv -----
module spc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_status,
  input logic                       out_pin_level,
  input logic [spc_pkg::AngleW-1:0] out_angle_now,
  input logic [spc_pkg::PulseW-1:0] out_pulse_now
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_pin_level) && $stable(out_angle_now) && $stable(out_pulse_now))
    else $error("stalled result changed");

  // one command in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second command accepted back to back");

  // a high pin needs a nonzero pulse width
  a_pin_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pin_level |-> out_pulse_now != '0)
    else $error("pin high with zero pulse width");

endmodule

bind servo_pulse_channel_core spc_checker u_spc_checker (.*);

// ----- bench/servo_pulse_channel_core_tb.sv -----
`timescale 1ns / 1ps

module servo_pulse_channel_core_tb;

  localparam int unsigned CfgIdxW = spc_pkg::CfgIdxW;
  localparam logic StAccept = 1'b0;
  localparam logic StReject = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = CfgIdxW'(spc_pkg::CFG_FRAME_TOP + 1);
  localparam int unsigned CfgIdxTop = 2 ** CfgIdxW - 1;

  typedef struct packed {
    logic            status;
    logic            pin_level;
    spc_pkg::angle_t angle_now;
    spc_pkg::pulse_t pulse_now;
  } chan_report_t;

  typedef struct {
    bit                 is_cfg;
    logic [CfgIdxW-1:0] cfg_idx;
    spc_pkg::pulse_t    cfg_val;
    spc_pkg::func_t     func;
    spc_pkg::angle_t    angle;
    spc_pkg::pulse_t    pulse;
    bit                 fixed;
    chan_report_t       want;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [spc_pkg::FuncW-1:0] in_func = '0;
  spc_pkg::angle_t           in_angle = '0;
  spc_pkg::pulse_t           in_pulse_us = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_status;
  logic                      out_pin_level;
  spc_pkg::angle_t           out_angle_now;
  spc_pkg::pulse_t           out_pulse_now;
  logic                      cfg_we = 1'b0;
  logic [CfgIdxW-1:0]        cfg_index = '0;
  spc_pkg::pulse_t           cfg_wdata = '0;

  // shadow registers and channel state
  spc_pkg::pulse_t cfg_min_pulse = spc_pkg::MinPulseRst;
  spc_pkg::pulse_t cfg_max_pulse = spc_pkg::MaxPulseRst;
  spc_pkg::angle_t cfg_max_angle = spc_pkg::MaxAngleRst;
  spc_pkg::pulse_t cfg_frame_top = spc_pkg::FrameTopRst;
  spc_pkg::pulse_t frame_cnt = '0;
  spc_pkg::pulse_t cur_pulse = '0;
  spc_pkg::angle_t cur_angle = '0;
  bit              running = 1'b0;
  bit              ready = 1'b0;

  chan_report_t pending_reports[$];
  int           bad_reports = 0;
  bit           row_fixed = 1'b0;
  chan_report_t row_want = '0;
  bit           calm = 1'b0;
  int           stall_left = 0;

  servo_pulse_channel_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_angle      (in_angle),
    .in_pulse_us   (in_pulse_us),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_pin_level (out_pin_level),
    .out_angle_now (out_angle_now),
    .out_pulse_now (out_pulse_now),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("servo_pulse_channel_core: mismatch");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 10));
    return int'($urandom_range(20, 40));
  endfunction

  function automatic bit calib_good();
    return (cfg_max_angle != 0) && (cfg_min_pulse < cfg_max_pulse);
  endfunction

  function automatic spc_pkg::pulse_t angle_width(spc_pkg::angle_t a);
    int unsigned span;
    span = 32'(cfg_max_pulse) - 32'(cfg_min_pulse);
    return spc_pkg::pulse_t'(32'(cfg_min_pulse) + (32'(a) * span) / 32'(cfg_max_angle));
  endfunction

  function automatic chan_report_t servo_cmd_apply(spc_pkg::func_t f, spc_pkg::angle_t a,
                                                   spc_pkg::pulse_t p);
    chan_report_t    r;
    int unsigned     span;
    spc_pkg::pulse_t pc;
    r.status = StAccept;
    if (f == spc_pkg::FN_TICK) begin
      frame_cnt = (frame_cnt >= cfg_frame_top) ? spc_pkg::pulse_t'(0) :
                  spc_pkg::pulse_t'(frame_cnt + 1);
    end else if (f == spc_pkg::FN_INIT) begin
      if (!calib_good()) begin
        r.status = StReject;
      end else begin
        cur_angle = cfg_max_angle >> 1;
        cur_pulse = angle_width(cur_angle);
        ready = 1'b1;
        running = 1'b1;
      end
    end else if (!ready) begin
      r.status = StReject;
    end else begin
      case (f)
        spc_pkg::FN_SET_ANGLE: begin
          if (!calib_good() || a > cfg_max_angle) begin
            r.status = StReject;
          end else begin
            cur_angle = a;
            cur_pulse = angle_width(a);
          end
        end
        spc_pkg::FN_SET_PULSE: begin
          if (!calib_good()) begin
            r.status = StReject;
          end else begin
            span = 32'(cfg_max_pulse) - 32'(cfg_min_pulse);
            pc = (p < cfg_min_pulse) ? cfg_min_pulse : (p > cfg_max_pulse) ? cfg_max_pulse : p;
            cur_pulse = pc;
            cur_angle = spc_pkg::angle_t'(((32'(pc) - 32'(cfg_min_pulse)) *
                                           32'(cfg_max_angle)) / span);
          end
        end
        spc_pkg::FN_START: running = 1'b1;
        spc_pkg::FN_STOP: running = 1'b0;
        spc_pkg::FN_GET_ANGLE: ;
        spc_pkg::FN_DEINIT: begin
          running = 1'b0;
          ready = 1'b0;
        end
        default: ;
      endcase
    end
    r.pin_level = running && (frame_cnt < cur_pulse);
    r.angle_now = cur_angle;
    r.pulse_now = cur_pulse;
    return r;
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= idle_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    chan_report_t got;
    chan_report_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_status, out_pin_level, out_angle_now, out_pulse_now};
        if (pending_reports.size() == 0) begin
          bad_reports++;
          if (bad_reports <= 10) $display("%0t: result transaction with none pending: %p", $time, got);
        end else begin
          want = pending_reports.pop_front();
          if (got !== want) begin
            bad_reports++;
            if (bad_reports <= 10)
              $display("%0t: exp/got status %0d/%0d pin %0d/%0d angle %0d/%0d pulse %0d/%0d",
                       $time, want.status, got.status, want.pin_level, got.pin_level,
                       want.angle_now, got.angle_now, want.pulse_now, got.pulse_now);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = servo_cmd_apply(spc_pkg::func_t'(in_func), in_angle, in_pulse_us);
        pending_reports.push_back(row_fixed ? row_want : want);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_cmd(spc_pkg::func_t f, spc_pkg::angle_t a, spc_pkg::pulse_t p, bit fx,
                          chan_report_t w);
    int g;
    g = calm ? 0 : idle_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_angle <= a;
    in_pulse_us <= p;
    row_fixed = fx;
    row_want = w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, spc_pkg::pulse_t val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      spc_pkg::CFG_MIN_PULSE: cfg_min_pulse = val;
      spc_pkg::CFG_MAX_PULSE: cfg_max_pulse = val;
      spc_pkg::CFG_MAX_ANGLE: cfg_max_angle = val[spc_pkg::AngleW-1:0];
      spc_pkg::CFG_FRAME_TOP: cfg_frame_top = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic stim_row_t cmd_row(spc_pkg::func_t f, spc_pkg::angle_t a,
                                        spc_pkg::pulse_t p);
    stim_row_t s;
    s.is_cfg = 1'b0;
    s.cfg_idx = '0;
    s.cfg_val = '0;
    s.func = f;
    s.angle = a;
    s.pulse = p;
    s.fixed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic stim_row_t checked_row(spc_pkg::func_t f, spc_pkg::angle_t a,
                                            spc_pkg::pulse_t p, logic st, logic pin,
                                            spc_pkg::angle_t an, spc_pkg::pulse_t pw);
    stim_row_t s;
    s = cmd_row(f, a, p);
    s.fixed = 1'b1;
    s.want = '{st, pin, an, pw};
    return s;
  endfunction

  function automatic stim_row_t reg_row(logic [CfgIdxW-1:0] idx, spc_pkg::pulse_t val);
    stim_row_t s;
    s = cmd_row(spc_pkg::FN_TICK, '0, '0);
    s.is_cfg = 1'b1;
    s.cfg_idx = idx;
    s.cfg_val = val;
    return s;
  endfunction

  initial begin
    stim_row_t       rows[$];
    int              r;
    int              k;
    spc_pkg::func_t  f;
    spc_pkg::angle_t a;
    spc_pkg::pulse_t p;
    spc_pkg::pulse_t mn;
    spc_pkg::pulse_t mx;
    spc_pkg::angle_t ma;
    spc_pkg::pulse_t ft;

    // not initialized: everything but tick and init is rejected
    rows.push_back(checked_row(spc_pkg::FN_SET_ANGLE, 8'd90, 16'd0, StReject, 1'b0, 8'd0, 16'd0));
    rows.push_back(checked_row(spc_pkg::FN_SET_PULSE, 8'd0, 16'hFFFF, StReject, 1'b0, 8'd0,
                               16'd0));
    rows.push_back(checked_row(spc_pkg::FN_START, 8'd0, 16'd0, StReject, 1'b0, 8'd0, 16'd0));
    rows.push_back(checked_row(spc_pkg::FN_STOP, 8'd0, 16'd0, StReject, 1'b0, 8'd0, 16'd0));
    rows.push_back(checked_row(spc_pkg::FN_GET_ANGLE, 8'd0, 16'd0, StReject, 1'b0, 8'd0, 16'd0));
    rows.push_back(checked_row(spc_pkg::FN_DEINIT, 8'd0, 16'd0, StReject, 1'b0, 8'd0, 16'd0));
    rows.push_back(checked_row(spc_pkg::FN_TICK, 8'hFF, 16'hFFFF, StAccept, 1'b0, 8'd0, 16'd0));
    rows.push_back(checked_row(spc_pkg::FN_INIT, 8'd0, 16'd0, StAccept, 1'b1, 8'd90, 16'd1500));
    rows.push_back(checked_row(spc_pkg::FN_SET_ANGLE, 8'd0, 16'd0, StAccept, 1'b1, 8'd0,
                               16'd1000));
    rows.push_back(checked_row(spc_pkg::FN_SET_ANGLE, 8'd180, 16'd0, StAccept, 1'b1, 8'd180,
                               16'd2000));
    rows.push_back(checked_row(spc_pkg::FN_SET_ANGLE, 8'd181, 16'd0, StReject, 1'b1, 8'd180,
                               16'd2000));
    rows.push_back(checked_row(spc_pkg::FN_SET_ANGLE, 8'd255, 16'd0, StReject, 1'b1, 8'd180,
                               16'd2000));
    rows.push_back(checked_row(spc_pkg::FN_SET_PULSE, 8'd0, 16'd0, StAccept, 1'b1, 8'd0,
                               16'd1000));
    rows.push_back(checked_row(spc_pkg::FN_SET_PULSE, 8'd0, 16'hFFFF, StAccept, 1'b1, 8'd180,
                               16'd2000));
    rows.push_back(cmd_row(spc_pkg::FN_SET_PULSE, 8'd0, 16'd1234));
    rows.push_back(cmd_row(spc_pkg::FN_STOP, 8'd0, 16'd0));
    rows.push_back(cmd_row(spc_pkg::FN_GET_ANGLE, 8'd0, 16'd0));
    rows.push_back(cmd_row(spc_pkg::FN_START, 8'd0, 16'd0));
    rows.push_back(cmd_row(spc_pkg::FN_INIT, 8'd0, 16'd0));
    rows.push_back(cmd_row(spc_pkg::FN_TICK, 8'd0, 16'd0));
    // frame top dropped below the counter
    rows.push_back(reg_row(spc_pkg::CFG_FRAME_TOP, 16'd1));
    rows.push_back(cmd_row(spc_pkg::FN_TICK, 8'd0, 16'd0));
    // calibration broken while ready
    rows.push_back(reg_row(spc_pkg::CFG_MAX_ANGLE, 16'd0));
    rows.push_back(cmd_row(spc_pkg::FN_SET_ANGLE, 8'd0, 16'd0));
    rows.push_back(cmd_row(spc_pkg::FN_INIT, 8'd0, 16'd0));
    rows.push_back(reg_row(spc_pkg::CFG_MAX_ANGLE, 16'd180));
    rows.push_back(reg_row(spc_pkg::CFG_MIN_PULSE, 16'd2000));
    rows.push_back(cmd_row(spc_pkg::FN_SET_PULSE, 8'd0, 16'd1500));
    rows.push_back(cmd_row(spc_pkg::FN_INIT, 8'd0, 16'd0));
    rows.push_back(cmd_row(spc_pkg::FN_DEINIT, 8'd0, 16'd0));
    rows.push_back(reg_row(CfgIdxSpare, 16'hFFFF));
    rows.push_back(cmd_row(spc_pkg::FN_INIT, 8'd0, 16'd0));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_idle();
        write_reg(rows[i].cfg_idx, rows[i].cfg_val);
      end else begin
        send_cmd(rows[i].func, rows[i].angle, rows[i].pulse, rows[i].fixed, rows[i].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          mn = '0;
          mx = '1;
          ma = '1;
          ft = 16'd1;
        end
        1: begin
          mn = 16'hFFFE;
          mx = '1;
          ma = 8'd1;
          ft = '1;
        end
        default: begin
          mn = spc_pkg::pulse_t'($urandom_range(0, 40));
          mx = mn + spc_pkg::pulse_t'($urandom_range(1, 60));
          ma = spc_pkg::angle_t'($urandom_range(1, 255));
          ft = spc_pkg::pulse_t'($urandom_range(1, 80));
          if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1) == 0) ma = '0;
            else mx = spc_pkg::pulse_t'($urandom_range(0, 32'(mn)));
          end
        end
      endcase
      write_reg(spc_pkg::CFG_MIN_PULSE, mn);
      write_reg(spc_pkg::CFG_MAX_PULSE, mx);
      write_reg(spc_pkg::CFG_MAX_ANGLE, spc_pkg::pulse_t'(ma));
      write_reg(spc_pkg::CFG_FRAME_TOP, ft);
      if ($urandom_range(0, 2) == 0)
        write_reg(CfgIdxW'($urandom_range(CfgIdxTop, 32'(CfgIdxSpare))),
                  spc_pkg::pulse_t'($urandom));
      calm = ($urandom_range(0, 3) == 0);

      send_cmd(spc_pkg::FN_INIT, spc_pkg::angle_t'($urandom), spc_pkg::pulse_t'($urandom),
               1'b0, '0);
      for (int n = 0; n < 180; n++) begin
        r = int'($urandom_range(0, 99));
        if (r < 45) f = spc_pkg::FN_TICK;
        else if (r < 52) f = spc_pkg::FN_INIT;
        else if (r < 64) f = spc_pkg::FN_SET_ANGLE;
        else if (r < 76) f = spc_pkg::FN_SET_PULSE;
        else if (r < 83) f = spc_pkg::FN_START;
        else if (r < 89) f = spc_pkg::FN_STOP;
        else if (r < 95) f = spc_pkg::FN_GET_ANGLE;
        else f = spc_pkg::FN_DEINIT;
        if ($urandom_range(0, 3) == 0) a = spc_pkg::angle_t'($urandom);
        else a = spc_pkg::angle_t'($urandom_range(0, 32'(cfg_max_angle) + 1));
        k = int'($urandom_range(0, 7));
        if (k == 0) p = spc_pkg::pulse_t'($urandom);
        else if (k == 1) p = spc_pkg::pulse_t'($urandom_range(0, 32'(cfg_min_pulse)));
        else p = spc_pkg::pulse_t'($urandom_range(32'(cfg_min_pulse), 32'(cfg_max_pulse) + 2));
        send_cmd(f, a, p, 1'b0, '0);
        if ($urandom_range(0, 149) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (40) @(negedge clk);
    if (bad_reports == 0 && pending_reports.size() == 0) begin
      $display("servo_pulse_channel_core: match");
    end else begin
      $display("servo_pulse_channel_core: mismatch");
    end
    $finish;
  end

endmodule
